// ----- rtl/gdm_pkg.sv -----
// Shared constants, types and the 5x7 font table of the dot-matrix glyph rasterizer.
`default_nettype none
package gdm_pkg;

  localparam int POSW = 12;
  localparam int SUMW = 13;
  localparam int GLYPH_W = 5;
  localparam int GLYPH_H = 7;
  localparam int GLYPH_ADVANCE = 6;

  localparam logic [7:0] FIRST_CODE = 8'h20;
  localparam logic [7:0] LAST_CODE = 8'h5F;
  localparam logic [7:0] SUB_CODE = 8'h3F;
  localparam logic [7:0] LOWER_FIRST = 8'h61;
  localparam logic [7:0] LOWER_LAST = 8'h7A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  localparam logic [1:0] MODE_PEN = 2'd0;
  localparam logic [1:0] MODE_DRAW = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  localparam logic CFG_COLS = 1'b0;
  localparam logic CFG_ROWS = 1'b1;

  typedef struct packed {
    logic dot;
    logic last;
  } gdm_walk_t;

  function automatic logic [5:0] glyph_index(input logic [7:0] code);
    logic [7:0] c;
    c = code;
    if (c >= LOWER_FIRST && c <= LOWER_LAST) begin
      c = c - CASE_GAP;
    end
    if (c < FIRST_CODE || c > LAST_CODE) begin
      c = SUB_CODE;
    end
    return 6'(c - FIRST_CODE);
  endfunction

  function automatic logic [39:0] font_word(input logic [5:0] idx);
    logic [39:0] w;
    unique case (idx)
      6'd0:  w = 40'h00_00_00_00_00;
      6'd1:  w = 40'h00_00_5F_00_00;
      6'd2:  w = 40'h00_07_00_07_00;
      6'd3:  w = 40'h14_7F_14_7F_14;
      6'd4:  w = 40'h24_2A_7F_2A_12;
      6'd5:  w = 40'h23_13_08_64_62;
      6'd6:  w = 40'h36_49_55_22_50;
      6'd7:  w = 40'h00_05_03_00_00;
      6'd8:  w = 40'h00_1C_22_41_00;
      6'd9:  w = 40'h00_41_22_1C_00;
      6'd10: w = 40'h14_08_3E_08_14;
      6'd11: w = 40'h08_08_3E_08_08;
      6'd12: w = 40'h00_50_30_00_00;
      6'd13: w = 40'h08_08_08_08_08;
      6'd14: w = 40'h00_60_60_00_00;
      6'd15: w = 40'h20_10_08_04_02;
      6'd16: w = 40'h3E_51_49_45_3E;
      6'd17: w = 40'h00_42_7F_40_00;
      6'd18: w = 40'h42_61_51_49_46;
      6'd19: w = 40'h21_41_45_4B_31;
      6'd20: w = 40'h18_14_12_7F_10;
      6'd21: w = 40'h27_45_45_45_39;
      6'd22: w = 40'h3C_4A_49_49_30;
      6'd23: w = 40'h01_71_09_05_03;
      6'd24: w = 40'h36_49_49_49_36;
      6'd25: w = 40'h06_49_49_29_1E;
      6'd26: w = 40'h00_36_36_00_00;
      6'd27: w = 40'h00_56_36_00_00;
      6'd28: w = 40'h00_08_14_22_41;
      6'd29: w = 40'h14_14_14_14_14;
      6'd30: w = 40'h41_22_14_08_00;
      6'd31: w = 40'h02_01_51_09_06;
      6'd32: w = 40'h32_49_79_41_3E;
      6'd33: w = 40'h7E_11_11_11_7E;
      6'd34: w = 40'h7F_49_49_49_36;
      6'd35: w = 40'h3E_41_41_41_22;
      6'd36: w = 40'h7F_41_41_22_1C;
      6'd37: w = 40'h7F_49_49_49_41;
      6'd38: w = 40'h7F_09_09_01_01;
      6'd39: w = 40'h3E_41_41_51_32;
      6'd40: w = 40'h7F_08_08_08_7F;
      6'd41: w = 40'h00_41_7F_41_00;
      6'd42: w = 40'h20_40_41_3F_01;
      6'd43: w = 40'h7F_08_14_22_41;
      6'd44: w = 40'h7F_40_40_40_40;
      6'd45: w = 40'h7F_02_04_02_7F;
      6'd46: w = 40'h7F_04_08_10_7F;
      6'd47: w = 40'h3E_41_41_41_3E;
      6'd48: w = 40'h7F_09_09_09_06;
      6'd49: w = 40'h3E_41_51_21_5E;
      6'd50: w = 40'h7F_09_19_29_46;
      6'd51: w = 40'h46_49_49_49_31;
      6'd52: w = 40'h01_01_7F_01_01;
      6'd53: w = 40'h3F_40_40_40_3F;
      6'd54: w = 40'h1F_20_40_20_1F;
      6'd55: w = 40'h7F_20_18_20_7F;
      6'd56: w = 40'h63_14_08_14_63;
      6'd57: w = 40'h03_04_78_04_03;
      6'd58: w = 40'h61_51_49_45_43;
      6'd59: w = 40'h00_00_7F_41_41;
      6'd60: w = 40'h02_04_08_10_20;
      6'd61: w = 40'h41_41_7F_00_00;
      6'd62: w = 40'h04_02_01_02_04;
      6'd63: w = 40'h40_40_40_40_40;
    endcase
    return w;
  endfunction

  // Column 0 is the leftmost column; bit 0 of a column is the top row.
  function automatic logic [GLYPH_H-1:0] font_column(input logic [5:0] idx,
                                                      input logic [2:0] col);
    logic [39:0] w;
    w = font_word(idx);
    return w[8 * (GLYPH_W - 1 - int'(col)) +: GLYPH_H];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/gdm_store.sv -----
// Frame store memory with one write port and one registered read port.
`default_nettype none
module gdm_store #(
  parameter int DEPTH = 4096,
  parameter int AW = 12
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/gdm_walker.sv -----
// Glyph walker that steps through font columns, rows and scaled sub-dots one per cycle.
`default_nettype none
module gdm_walker #(
  parameter int SCW = 4,
  parameter int OXW = 6,
  parameter int OYW = 6
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               go,
  input  wire logic [5:0]         glyph,
  input  wire logic [SCW-1:0]     sc,
  output gdm_pkg::gdm_walk_t      walk,
  output logic      [OXW-1:0]     ox,
  output logic      [OYW-1:0]     oy
);

  logic           run_r, run_nxt;
  logic [2:0]     col_r, col_nxt;
  logic [2:0]     row_r, row_nxt;
  logic [SCW-1:0] dx_r, dx_nxt;
  logic [SCW-1:0] dy_r, dy_nxt;
  logic [OXW-1:0] oxb_r, oxb_nxt;
  logic [OYW-1:0] oyb_r, oyb_nxt;

  logic [gdm_pkg::GLYPH_H-1:0] bits;
  logic lit, dx_end, dy_end, row_done, col_done, last;

  assign bits = gdm_pkg::font_column(glyph, col_r);
  assign lit = bits[row_r];
  assign dx_end = (dx_r == sc - SCW'(1));
  assign dy_end = (dy_r == sc - SCW'(1));
  assign row_done = !lit || (dx_end && dy_end);
  assign col_done = row_done && (row_r == 3'(gdm_pkg::GLYPH_H - 1));
  assign last = col_done && (col_r == 3'(gdm_pkg::GLYPH_W - 1));

  assign walk.dot = run_r && lit;
  assign walk.last = run_r && last;
  assign ox = oxb_r + OXW'(dx_r);
  assign oy = oyb_r + OYW'(dy_r);

  always_comb begin
    run_nxt = run_r;
    col_nxt = col_r;
    row_nxt = row_r;
    dx_nxt = dx_r;
    dy_nxt = dy_r;
    oxb_nxt = oxb_r;
    oyb_nxt = oyb_r;
    if (go) begin
      run_nxt = 1'b1;
      col_nxt = '0;
      row_nxt = '0;
      dx_nxt = '0;
      dy_nxt = '0;
      oxb_nxt = '0;
      oyb_nxt = '0;
    end else if (run_r) begin
      if (!row_done) begin
        if (dx_end) begin
          dx_nxt = '0;
          dy_nxt = dy_r + SCW'(1);
        end else begin
          dx_nxt = dx_r + SCW'(1);
        end
      end else begin
        dx_nxt = '0;
        dy_nxt = '0;
        if (col_done) begin
          row_nxt = '0;
          oyb_nxt = '0;
          col_nxt = col_r + 3'd1;
          oxb_nxt = oxb_r + OXW'(sc);
          if (last) begin
            run_nxt = 1'b0;
          end
        end else begin
          row_nxt = row_r + 3'd1;
          oyb_nxt = oyb_r + OYW'(sc);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
    end
    col_r <= col_nxt;
    row_r <= row_nxt;
    dx_r <= dx_nxt;
    dy_r <= dy_nxt;
    oxb_r <= oxb_nxt;
    oyb_r <= oyb_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/glyph_rasterizer_dot_matrix.sv -----
// Top level of the dot-matrix glyph rasterizer with frame store, pen and request sequencer.
// Set pen: the result strobe is registered from the request; read dot: the store read is
// registered, then the result; clear: every store entry is written with zero before the
// result. Draw: the glyph walker writes one frame store dot per cycle at effective scale s.
// One request at a time; busy stays high until the result strobe is issued.
// Reset (and a change of the active area) clears all MAX_COLUMNS*MAX_ROWS store entries.
`default_nettype none
module glyph_rasterizer_dot_matrix #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS = 32,
  parameter int MAX_SCALE = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [1:0]                      in_mode,
  input  wire logic [7:0]                      in_char_code,
  input  wire logic signed [gdm_pkg::POSW-1:0] in_pos_x,
  input  wire logic signed [gdm_pkg::POSW-1:0] in_pos_y,
  input  wire logic [3:0]                      in_scale,
  input  wire logic [7:0]                      in_level,
  output logic                                 out_valid,
  output logic [7:0]                           out_dot_level,
  output logic                                 out_in_bounds,
  input  wire logic                            cfg_we,
  input  wire logic                            cfg_index,
  input  wire logic [7:0]                      cfg_data
);

  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW = $clog2(DEPTH);
  localparam int XW = $clog2(MAX_COLUMNS);
  localparam int YW = $clog2(MAX_ROWS);
  localparam int ACW = $clog2(MAX_COLUMNS + 1);
  localparam int ARW = $clog2(MAX_ROWS + 1);
  localparam int SCW = $clog2(MAX_SCALE + 1);
  localparam int OXW = $clog2(gdm_pkg::GLYPH_W * MAX_SCALE);
  localparam int OYW = $clog2(gdm_pkg::GLYPH_H * MAX_SCALE);
  localparam int SUMW = gdm_pkg::SUMW;
  localparam int POSW = gdm_pkg::POSW;
  localparam int ACOL_RST = (MAX_COLUMNS < 128) ? MAX_COLUMNS : 128;
  localparam int AROW_RST = (MAX_ROWS < 32) ? MAX_ROWS : 32;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_DRAW = 3'd2;
  localparam logic [2:0] S_FINISH = 3'd3;
  localparam logic [2:0] S_READ = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [AW-1:0]          clr_cnt_r, clr_cnt_nxt;
  logic                   clr_reply_r, clr_reply_nxt;
  logic signed [POSW-1:0] pen_x_r, pen_x_nxt;
  logic signed [POSW-1:0] pen_y_r, pen_y_nxt;
  logic [ACW-1:0]         ac_r, ac_nxt;
  logic [ARW-1:0]         ar_r, ar_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             out_level_r, out_level_nxt;
  logic                   out_ib_r, out_ib_nxt;
  logic                   pa_vld_r;
  logic [XW-1:0]          pa_x_r;
  logic [YW-1:0]          pa_y_r;
  logic [5:0]             glyph_r;
  logic [SCW-1:0]         sc_r;
  logic [7:0]             lvl_r;
  logic                   rd_in_r;

  logic                   accept, cfg_clear, walk_go;
  logic [SCW-1:0]         sc_in;
  logic [ACW-1:0]         ac_in;
  logic [ARW-1:0]         ar_in;
  gdm_pkg::gdm_walk_t     walk;
  logic [OXW-1:0]         wk_ox;
  logic [OYW-1:0]         wk_oy;
  logic signed [SUMW-1:0] dot_x, dot_y, rd_x, rd_y;
  logic                   dot_in, rd_in;
  logic                   st_we;
  logic [AW-1:0]          st_waddr, st_raddr;
  logic [7:0]             st_wdata, st_rdata;

  assign busy = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign walk_go = accept && (in_mode == gdm_pkg::MODE_DRAW);

  always_comb begin
    if (in_scale == '0) begin
      sc_in = SCW'(1);
    end else if (6'(in_scale) > 6'(MAX_SCALE)) begin
      sc_in = SCW'(MAX_SCALE);
    end else begin
      sc_in = SCW'(in_scale);
    end
  end

  always_comb begin
    if (cfg_data == '0) begin
      ac_in = ACW'(1);
    end else if (11'(cfg_data) > 11'(MAX_COLUMNS)) begin
      ac_in = ACW'(MAX_COLUMNS);
    end else begin
      ac_in = ACW'(cfg_data);
    end
    if (cfg_data[5:0] == '0) begin
      ar_in = ARW'(1);
    end else if (10'(cfg_data[5:0]) > 10'(MAX_ROWS)) begin
      ar_in = ARW'(MAX_ROWS);
    end else begin
      ar_in = ARW'(cfg_data[5:0]);
    end
  end

  always_comb begin
    ac_nxt = ac_r;
    ar_nxt = ar_r;
    cfg_clear = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        gdm_pkg::CFG_COLS: begin
          ac_nxt = ac_in;
          cfg_clear = (ac_in != ac_r);
        end
        gdm_pkg::CFG_ROWS: begin
          ar_nxt = ar_in;
          cfg_clear = (ar_in != ar_r);
        end
      endcase
    end
  end

  gdm_walker #(
    .SCW(SCW),
    .OXW(OXW),
    .OYW(OYW)
  ) u_walker (
    .clk(clk),
    .rst_n(rst_n),
    .go(walk_go),
    .glyph(glyph_r),
    .sc(sc_r),
    .walk(walk),
    .ox(wk_ox),
    .oy(wk_oy)
  );

  assign dot_x = SUMW'(pen_x_r) + SUMW'(wk_ox);
  assign dot_y = SUMW'(pen_y_r) + SUMW'(wk_oy);
  assign rd_x = SUMW'(in_pos_x);
  assign rd_y = SUMW'(in_pos_y);

  assign dot_in = !dot_x[SUMW-1] && (dot_x[SUMW-2:0] < (SUMW-1)'(ac_r)) &&
                  !dot_y[SUMW-1] && (dot_y[SUMW-2:0] < (SUMW-1)'(ar_r));
  assign rd_in = !rd_x[SUMW-1] && (rd_x[SUMW-2:0] < (SUMW-1)'(ac_r)) &&
                 !rd_y[SUMW-1] && (rd_y[SUMW-2:0] < (SUMW-1)'(ar_r));

  always_comb begin
    if (state_r == S_CLEAR) begin
      st_we = 1'b1;
      st_waddr = clr_cnt_r;
      st_wdata = '0;
    end else begin
      st_we = pa_vld_r;
      st_waddr = AW'(AW'(pa_y_r) * AW'(MAX_COLUMNS)) + AW'(pa_x_r);
      st_wdata = lvl_r;
    end
  end

  assign st_raddr = AW'(AW'(rd_y[YW-1:0]) * AW'(MAX_COLUMNS)) + AW'(rd_x[XW-1:0]);

  gdm_store #(
    .DEPTH(DEPTH),
    .AW(AW)
  ) u_store (
    .clk(clk),
    .we(st_we),
    .waddr(st_waddr),
    .wdata(st_wdata),
    .raddr(st_raddr),
    .rdata(st_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    clr_cnt_nxt = clr_cnt_r;
    clr_reply_nxt = clr_reply_r;
    pen_x_nxt = pen_x_r;
    pen_y_nxt = pen_y_r;
    out_valid_nxt = 1'b0;
    out_level_nxt = '0;
    out_ib_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            gdm_pkg::MODE_PEN: begin
              pen_x_nxt = in_pos_x;
              pen_y_nxt = in_pos_y;
              out_valid_nxt = 1'b1;
            end
            gdm_pkg::MODE_DRAW: begin
              state_nxt = S_DRAW;
            end
            gdm_pkg::MODE_READ: begin
              state_nxt = S_READ;
            end
            gdm_pkg::MODE_CLEAR: begin
              state_nxt = S_CLEAR;
              clr_cnt_nxt = '0;
              clr_reply_nxt = 1'b1;
            end
          endcase
        end
      end
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
          out_valid_nxt = clr_reply_r;
          clr_reply_nxt = 1'b0;
        end
      end
      S_DRAW: begin
        if (walk.last) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        pen_x_nxt = pen_x_r + POSW'(POSW'(sc_r) * POSW'(gdm_pkg::GLYPH_ADVANCE));
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      S_READ: begin
        out_valid_nxt = 1'b1;
        out_ib_nxt = rd_in_r;
        out_level_nxt = rd_in_r ? st_rdata : '0;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cfg_clear) begin
      state_nxt = S_CLEAR;
      clr_cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_cnt_r <= '0;
      clr_reply_r <= 1'b0;
      pen_x_r <= '0;
      pen_y_r <= '0;
      ac_r <= ACW'(ACOL_RST);
      ar_r <= ARW'(AROW_RST);
      out_valid_r <= 1'b0;
      pa_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      clr_reply_r <= clr_reply_nxt;
      pen_x_r <= pen_x_nxt;
      pen_y_r <= pen_y_nxt;
      ac_r <= ac_nxt;
      ar_r <= ar_nxt;
      out_valid_r <= out_valid_nxt;
      pa_vld_r <= walk.dot && dot_in;
    end
    out_level_r <= out_level_nxt;
    out_ib_r <= out_ib_nxt;
    pa_x_r <= dot_x[XW-1:0];
    pa_y_r <= dot_y[YW-1:0];
    if (accept) begin
      glyph_r <= gdm_pkg::glyph_index(in_char_code);
      sc_r <= sc_in;
      lvl_r <= in_level;
      rd_in_r <= rd_in;
    end
  end

  assign out_valid = out_valid_r;
  assign out_dot_level = out_level_r;
  assign out_in_bounds = out_ib_r;

  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start)))
    else $error("result strobe without a request in progress");

  a_walk_only_drawing: assert property (@(posedge clk) disable iff (!rst_n)
    walk.dot |-> (state_r == S_DRAW))
    else $error("glyph walker active outside a draw");

  a_write_only_drawing: assert property (@(posedge clk) disable iff (!rst_n)
    pa_vld_r |-> (state_r == S_DRAW || state_r == S_FINISH))
    else $error("dot write outside a draw");

  a_read_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> $past(accept && in_mode == gdm_pkg::MODE_READ))
    else $error("read state entered without a read request");

endmodule
`default_nettype wire
